// ----- src/min_priority_queue_decrease_key_defines.svh -----
// ----------------------------------------------------------------------------
// min priority queue assertion macros
// shared property forms for the queue checker, clocked on clk, reset rst_n
// ----------------------------------------------------------------------------
`ifndef MIN_PRIORITY_QUEUE_DECREASE_KEY_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_DECREASE_KEY_DEFINES_SVH

// same-cycle implication
`define MPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpq check failed");

// next-cycle implication
`define MPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpq check failed");

`endif

// ----- src/mpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mpq_pkg
// shared sizes, item types, codes and control structs of the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpq_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_BITS   = 8;
  localparam int VALUE_BITS = 16;
  localparam int IDX_BITS   = $clog2(CAPACITY);
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_POP = 1'b1;

  localparam logic [1:0] FAULT_OK    = 2'd0;
  localparam logic [1:0] FAULT_EMPTY = 2'd1;
  localparam logic [1:0] FAULT_FULL  = 2'd2;

  typedef struct packed {
    logic                  kind;
    logic [KEY_BITS-1:0]   item_key;
    logic [VALUE_BITS-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   popped_key;
    logic [VALUE_BITS-1:0] popped_value;
    logic                  now_empty;
    logic [1:0]            fault;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       scan;
    logic       shift_init;
    logic       shift;
    logic       place;
    logic       pop_commit;
    logic       finish;
    logic [1:0] fin_fault;
  } mpq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic scan_done;
    logic shift_done;
    logic found;
    logic less;
  } mpq_status_t;

endpackage

// ----- src/min_priority_queue_decrease_key.sv -----
// ----------------------------------------------------------------------------
// min_priority_queue_decrease_key
// sorted min priority queue with decrease key, one result item per item
// ----------------------------------------------------------------------------
// a remove passes through a check state and, on a non-empty queue, a commit
// state before the result strobe; an add that changes nothing ends after the scan,
//   and one that inserts or lowers an entry makes one pass over the entry ram port to find the
//   key and the sorted slot, then one pass that moves entries up a slot
// one item at a time; the next item may be accepted in the cycle of the strobe
// synchronous active-low reset empties the queue; the receiver cannot stall
`timescale 1ns / 1ps

module min_priority_queue_decrease_key import mpq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  // command and status between sequencer and datapath
  mpq_cmd_t    cmd;
  mpq_status_t status;

  // sequencer: picks pop or add path, scans, then shifts and places when the add changes the queue
  mpq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_item.kind),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  // datapath: entries live in a ring buffer, so a pop only moves the head;
  // an add scans from the head for key match and first value >= new value,
  // then shifts the entries between that slot and the end (or the old slot
  // of a lowered key) up by one and writes the item into the gap
  mpq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- src/mpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// mpq_ctrl
// sequencer of the queue: scan, shift, place and pop steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpq_ctrl import mpq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        in_kind,
  input  mpq_status_t status,
  output mpq_cmd_t    cmd,
  output logic        busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POP   = 3'd1;
  localparam logic [2:0] S_POPW  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_PLACE = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (in_kind == KIND_POP) ? S_POP : S_SCAN;
        end
      end
      S_POP: begin
        if (status.empty) begin
          cmd.finish    = 1'b1;
          cmd.fin_fault = FAULT_EMPTY;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        cmd.pop_commit = 1'b1;
        cmd.finish     = 1'b1;
        cmd.fin_fault  = FAULT_OK;
        state_nxt      = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          priority if (status.found && !status.less) begin
            cmd.finish    = 1'b1;
            cmd.fin_fault = FAULT_OK;
            state_nxt     = S_IDLE;
          end else if (!status.found && status.full) begin
            cmd.finish    = 1'b1;
            cmd.fin_fault = FAULT_FULL;
            state_nxt     = S_IDLE;
          end else begin
            cmd.shift_init = 1'b1;
            state_nxt      = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (status.shift_done) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place     = 1'b1;
        cmd.finish    = 1'b1;
        cmd.fin_fault = FAULT_OK;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/mpq_dp.sv -----
// ----------------------------------------------------------------------------
// mpq_dp
// entry memory as a ring, scan compare, shift pipeline and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpq_dp import mpq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_item,
  input  mpq_cmd_t    cmd,
  output mpq_status_t status,
  output logic        out_valid,
  output out_item_t   out_item
);

  localparam int SUM_BITS  = IDX_BITS + 1;
  localparam int WORD_BITS = KEY_BITS + VALUE_BITS;

  // ring slot of a position counted from the head
  function automatic logic [IDX_BITS-1:0] phys(input logic [IDX_BITS-1:0] head,
                                               input logic [CNT_BITS-1:0] lidx);
    logic [SUM_BITS-1:0] sum;
    sum = SUM_BITS'(head) + SUM_BITS'(lidx[IDX_BITS-1:0]);
    if (sum >= SUM_BITS'(CAPACITY)) begin
      sum = sum - SUM_BITS'(CAPACITY);
    end
    return sum[IDX_BITS-1:0];
  endfunction

  logic [WORD_BITS-1:0]  mem_r [CAPACITY];
  logic [WORD_BITS-1:0]  rdata_r;

  in_item_t              item_r,      item_nxt;
  logic [IDX_BITS-1:0]   head_r,      head_nxt;
  logic [CNT_BITS-1:0]   count_r,     count_nxt;
  logic [CNT_BITS-1:0]   idx_r,       idx_nxt;
  logic [CNT_BITS-1:0]   rd_idx_r,    rd_idx_nxt;
  logic                  rdv_r,       rdv_nxt;
  logic [CNT_BITS-1:0]   sidx_r,      sidx_nxt;
  logic [CNT_BITS-1:0]   pos_r,       pos_nxt;
  logic                  pos_hit_r,   pos_hit_nxt;
  logic                  match_r,     match_nxt;
  logic [CNT_BITS-1:0]   match_idx_r, match_idx_nxt;
  logic [VALUE_BITS-1:0] match_val_r, match_val_nxt;
  logic                  grow_r,      grow_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r,       out_nxt;

  logic                  scan_issue;
  logic                  shift_issue;
  logic [CNT_BITS-1:0]   rd_lidx;
  logic [IDX_BITS-1:0]   rd_addr;
  logic                  wr_en;
  logic [IDX_BITS-1:0]   wr_addr;
  logic [WORD_BITS-1:0]  wr_data;
  logic [KEY_BITS-1:0]   rkey;
  logic [VALUE_BITS-1:0] rval;

  assign rkey = rdata_r[WORD_BITS-1:VALUE_BITS];
  assign rval = rdata_r[VALUE_BITS-1:0];

  assign scan_issue  = cmd.scan && (idx_r != count_r);
  assign shift_issue = cmd.shift && (sidx_r != pos_r);

  // read port: scan walks up, shift walks down, otherwise the head
  always_comb begin
    priority if (scan_issue) begin
      rd_lidx = idx_r;
    end else if (shift_issue) begin
      rd_lidx = sidx_r - CNT_BITS'(1);
    end else begin
      rd_lidx = '0;
    end
  end

  assign rd_addr = phys(head_r, rd_lidx);

  // write port: shifted entry one slot up, or the new entry at its place
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = phys(head_r, pos_r);
    wr_data = {item_r.item_key, item_r.item_value};
    priority if (cmd.shift && rdv_r) begin
      wr_en   = 1'b1;
      wr_addr = phys(head_r, rd_idx_r + CNT_BITS'(1));
      wr_data = rdata_r;
    end else if (cmd.place) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rdata_r <= mem_r[rd_addr];
  end

  always_comb begin
    item_nxt      = item_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    rd_idx_nxt    = rd_idx_r;
    rdv_nxt       = rdv_r;
    sidx_nxt      = sidx_r;
    pos_nxt       = pos_r;
    pos_hit_nxt   = pos_hit_r;
    match_nxt     = match_r;
    match_idx_nxt = match_idx_r;
    match_val_nxt = match_val_r;
    grow_nxt      = grow_r;
    out_nxt       = out_r;

    if (cmd.load) begin
      item_nxt    = in_item;
      idx_nxt     = '0;
      rdv_nxt     = 1'b0;
      match_nxt   = 1'b0;
      pos_hit_nxt = 1'b0;
      pos_nxt     = count_r;
    end

    if (cmd.scan) begin
      rdv_nxt = scan_issue;
      if (scan_issue) begin
        rd_idx_nxt = idx_r;
        idx_nxt    = idx_r + CNT_BITS'(1);
      end
      if (rdv_r) begin
        if (!match_r && (rkey == item_r.item_key)) begin
          match_nxt     = 1'b1;
          match_idx_nxt = rd_idx_r;
          match_val_nxt = rval;
        end
        if (!pos_hit_r && (rval >= item_r.item_value)) begin
          pos_hit_nxt = 1'b1;
          pos_nxt     = rd_idx_r;
        end
      end
    end

    // a lowered entry is overwritten by the shift, a new one grows the queue
    if (cmd.shift_init) begin
      sidx_nxt = match_r ? match_idx_r : count_r;
      grow_nxt = !match_r;
      rdv_nxt  = 1'b0;
    end

    if (cmd.shift) begin
      rdv_nxt = shift_issue;
      if (shift_issue) begin
        rd_idx_nxt = sidx_r - CNT_BITS'(1);
        sidx_nxt   = sidx_r - CNT_BITS'(1);
      end
    end

    if (cmd.place && grow_r) begin
      count_nxt = count_r + CNT_BITS'(1);
    end

    if (cmd.pop_commit) begin
      count_nxt = count_r - CNT_BITS'(1);
      head_nxt  = (head_r == IDX_BITS'(CAPACITY - 1)) ? '0 : head_r + IDX_BITS'(1);
    end

    out_valid_nxt = cmd.finish;
    if (cmd.finish) begin
      out_nxt.popped_key   = cmd.pop_commit ? rkey : '0;
      out_nxt.popped_value = cmd.pop_commit ? rval : '0;
      out_nxt.now_empty    = (count_nxt == '0);
      out_nxt.fault        = cmd.fin_fault;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    idx_r       <= idx_nxt;
    rd_idx_r    <= rd_idx_nxt;
    sidx_r      <= sidx_nxt;
    pos_r       <= pos_nxt;
    pos_hit_r   <= pos_hit_nxt;
    match_r     <= match_nxt;
    match_idx_r <= match_idx_nxt;
    match_val_r <= match_val_nxt;
    grow_r      <= grow_nxt;
    out_r       <= out_nxt;
  end

  assign status.empty      = (count_r == '0);
  assign status.full       = (count_r == CNT_BITS'(CAPACITY));
  assign status.scan_done  = (idx_r == count_r) && !rdv_r;
  assign status.shift_done = (sidx_r == pos_r) && !rdv_r;
  assign status.found      = match_r;
  assign status.less       = (item_r.item_value < match_val_r);

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- src/mpq_chk.sv -----
// ----------------------------------------------------------------------------
// mpq_chk
// port-level checks on the queue, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "min_priority_queue_decrease_key_defines.svh"

module mpq_chk import mpq_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // an accepted item always makes the block busy after the accept
  `MPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // a result only follows work in progress
  `MPQ_ASSERT_NOW(a_strobe_after_work, out_valid, $past(busy))

  // a remove on an empty queue reports zeros and an empty queue
  `MPQ_ASSERT_NOW(a_empty_pop, out_valid && out_item.fault == FAULT_EMPTY, out_item.now_empty && out_item.popped_key == '0 && out_item.popped_value == '0)

  // a dropped add means the queue is full, so never empty
  `MPQ_ASSERT_NOW(a_full_nonempty, out_valid && out_item.fault == FAULT_FULL, !out_item.now_empty)

endmodule

bind min_priority_queue_decrease_key mpq_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ----- tb/mpq_order_checker.sv -----
// ----------------------------------------------------------------------------
// mpq_order_checker
// watches both channels of the queue, keeps a shadow sorted queue and checks
// every result item against the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpq_order_checker import mpq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        mismatches,
  output int        awaited,
  output int        pops_seen,
  output int        keys_lowered,
  output int        empty_pops,
  output int        full_drops
);

  // shadow queue, ascending by value, slot 0 is served next
  logic [KEY_BITS-1:0]   held_key   [CAPACITY];
  logic [VALUE_BITS-1:0] held_value [CAPACITY];
  int                    held_count;

  out_item_t awaited_q [$];

  function automatic void drop_slot(input int pos);
    int i;
    for (i = pos; i + 1 < held_count; i++) begin
      held_key[i]   = held_key[i+1];
      held_value[i] = held_value[i+1];
    end
    held_count--;
  endfunction

  // ahead of the first entry whose value is >= v, so ties go newest first
  function automatic void insert_sorted(input logic [KEY_BITS-1:0] k,
                                        input logic [VALUE_BITS-1:0] v);
    int pos;
    int i;
    pos = 0;
    while (pos < held_count && held_value[pos] < v) pos++;
    for (i = held_count; i > pos; i--) begin
      held_key[i]   = held_key[i-1];
      held_value[i] = held_value[i-1];
    end
    held_key[pos]   = k;
    held_value[pos] = v;
    held_count++;
  endfunction

  function automatic out_item_t predict_result(input in_item_t it);
    out_item_t r;
    int        hit;
    int        i;
    r   = '0;
    hit = -1;
    if (it.kind == KIND_POP) begin
      if (held_count == 0) begin
        r.fault = FAULT_EMPTY;
        empty_pops++;
      end else begin
        r.popped_key   = held_key[0];
        r.popped_value = held_value[0];
        drop_slot(0);
        pops_seen++;
      end
    end else begin
      for (i = 0; i < held_count; i++) begin
        if (hit < 0 && held_key[i] == it.item_key) hit = i;
      end
      if (hit >= 0) begin
        // only a strictly smaller value lowers and re-sorts the entry
        if (it.item_value < held_value[hit]) begin
          drop_slot(hit);
          insert_sorted(it.item_key, it.item_value);
          keys_lowered++;
        end
      end else if (held_count >= CAPACITY) begin
        r.fault = FAULT_FULL;
        full_drops++;
      end else begin
        insert_sorted(it.item_key, it.item_value);
      end
    end
    r.now_empty = (held_count == 0);
    return r;
  endfunction

  task automatic report_bad(input string what, input out_item_t want, input out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected key %0d value %0d empty %0b fault %0d, got key %0d value %0d empty %0b fault %0d",
               $time, what, want.popped_key, want.popped_value, want.now_empty, want.fault,
               got.popped_key, got.popped_value, got.now_empty, got.fault);
  endtask

  always @(posedge clk) begin : check_edge
    out_item_t want;
    if (!rst_n) begin
      held_count   = 0;
      mismatches   = 0;
      pops_seen    = 0;
      keys_lowered = 0;
      empty_pops   = 0;
      full_drops   = 0;
      awaited_q.delete();
      awaited <= 0;
    end else begin
      // a strobe always belongs to an item accepted at an earlier edge
      if (out_valid) begin
        if (awaited_q.size() == 0) begin
          report_bad("result item with nothing awaited", '0, out_item);
        end else begin
          want = awaited_q.pop_front();
          if (out_item.popped_key   !== want.popped_key   ||
              out_item.popped_value !== want.popped_value ||
              out_item.now_empty    !== want.now_empty    ||
              out_item.fault        !== want.fault)
            report_bad("result item mismatch", want, out_item);
        end
      end
      if (start && !busy) awaited_q.push_back(predict_result(in_item));
      awaited <= awaited_q.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// drives add and remove items into the sorted min priority queue under
// several idle patterns; mpq_order_checker predicts and checks each result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mpq_pkg::*;

  // margin for the slowest add, a full scan and a full shift pass, plus sender gaps
  localparam int TAIL_CYCLES    = 2 * CAPACITY + 10;
  localparam int WATCHDOG_LIMIT = 3000;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  int mismatches;
  int awaited;
  int pops_seen;
  int keys_lowered;
  int empty_pops;
  int full_drops;
  int items_sent   = 0;
  int stall_cycles = 0;

  always #5 clk = ~clk;

  min_priority_queue_decrease_key dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  mpq_order_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .mismatches   (mismatches),
    .awaited      (awaited),
    .pops_seen    (pops_seen),
    .keys_lowered (keys_lowered),
    .empty_pops   (empty_pops),
    .full_drops   (full_drops)
  );

  // watchdog: any accepted item or result strobe counts as progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic in_item_t make_item(input logic kind,
                                         input logic [KEY_BITS-1:0] k,
                                         input logic [VALUE_BITS-1:0] v);
    in_item_t it;
    it.kind       = kind;
    it.item_key   = k;
    it.item_value = v;
    return it;
  endfunction

  // random item; narrow keys keep a small key set so decrease-key hits often
  function automatic in_item_t random_item(input int pop_pct, input bit narrow);
    in_item_t it;
    int       pick;
    it.kind       = ($urandom_range(99) < pop_pct) ? KIND_POP : KIND_ADD;
    it.item_key   = KEY_BITS'($urandom());
    it.item_value = VALUE_BITS'($urandom());
    if (narrow) begin
      it.item_key = KEY_BITS'($urandom_range(15));
      // flipped small keys reach the top bits too
      if ($urandom_range(3) == 0) it.item_key = ~it.item_key;
    end
    pick = int'($urandom_range(7));
    case (pick)
      0: it.item_value = '0;
      1: it.item_value = '1;
      2, 3: it.item_value = VALUE_BITS'($urandom_range(7));   // lots of ties
      default: ;
    endcase
    return it;
  endfunction

  // called at a rising edge; returns at the edge where the item is accepted,
  // leaving start high so the next item can follow without a gap
  task automatic send_item(input in_item_t it, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // hold off the sender until every awaited result has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (awaited != 0);
  endtask

  task automatic run_segment(input int n, input int pop_pct, input bit narrow,
                             input int idle_pct);
    int i;
    for (i = 0; i < n; i++) send_item(random_item(pop_pct, narrow), idle_pct);
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pop, key and value extremes, ties, decrease-key cases
    send_item(make_item(KIND_POP, 8'h00, 16'h0000), 0);  // remove on empty
    send_item(make_item(KIND_ADD, 8'h00, 16'h8000), 0);
    send_item(make_item(KIND_ADD, 8'hFF, 16'hFFFF), 0);
    send_item(make_item(KIND_ADD, 8'hAA, 16'h8000), 0);  // tie, goes ahead of key 0
    send_item(make_item(KIND_ADD, 8'h55, 16'h0000), 0);
    send_item(make_item(KIND_ADD, 8'hAA, 16'h8000), 0);  // equal value, no change
    send_item(make_item(KIND_ADD, 8'hAA, 16'h9000), 0);  // larger value, no change
    send_item(make_item(KIND_ADD, 8'hFF, 16'h7FFF), 0);  // lowered, moves up
    send_item(make_item(KIND_ADD, 8'h00, 16'h7FFF), 0);  // lowered onto a tie
    send_item(make_item(KIND_ADD, 8'h55, 16'h0000), 0);
    send_item(make_item(KIND_POP, 8'hFF, 16'hFFFF), 0);
    send_item(make_item(KIND_POP, 8'h00, 16'h0000), 0);
    send_item(make_item(KIND_POP, 8'h00, 16'h0000), 0);
    send_item(make_item(KIND_POP, 8'h00, 16'h0000), 0);
    send_item(make_item(KIND_POP, 8'h00, 16'h0000), 0);
    send_item(make_item(KIND_POP, 8'h00, 16'h0000), 0);  // empty again
    wait_drained();

    // random: churn on few keys, fill past capacity, drain, under idle mixes
    run_segment(200, 40, 1'b1, 0);
    run_segment(120, 10, 1'b0, 0);    // fills to full, then drops
    run_segment(100, 85, 1'b0, 87);
    run_segment(150, 10, 1'b0, 9);
    run_segment(150, 40, 1'b1, 87);
    run_segment(100, 10, 1'b0, 0);
    run_segment(100, 85, 1'b0, 9);
    run_segment(150, 40, 1'b1, 9);

    // let any late strobe show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d items: %0d pops, %0d keys lowered", items_sent, pops_seen,
             keys_lowered);
    $display("faults seen: %0d pops on empty queue, %0d adds dropped when full",
             empty_pops, full_drops);
    if (mismatches == 0 && awaited == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, awaited);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
